[hdl/spq_pkg.sv]
// spq_pkg: shared types and constants for the stable priority queue core
// no dependencies; imported by the controller, datapath and top level
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int TAG_BITS = 16;
  localparam int ID_BITS  = 16;
  localparam int URG_BITS = 32;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_POP     = 2'd1,
    REQ_UPGRADE = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_EMPTY        = 3'd1,
    STAT_NOT_FOUND    = 3'd2,
    STAT_NOT_URGENT   = 3'd3,
    STAT_FULL         = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_PLACE = 1'b1
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [ID_BITS-1:0]         entry_id;
    logic signed [URG_BITS-1:0] urgency;
  } request_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic [ID_BITS-1:0]         removed_id;
    logic                       front_valid;
    logic [ID_BITS-1:0]         front_id;
    logic signed [URG_BITS-1:0] front_urgency;
    logic [4:0]                 occupancy;
  } result_t;

  typedef struct packed {
    logic exec;
    logic place;
  } ctrl_cmd_t;

  typedef struct packed {
    logic move;
  } dp_stat_t;

endpackage
`default_nettype wire

[hdl/spq_ctrl.sv]
// spq_ctrl: sequencing state machine for the queue core
// depends on spq_pkg; drives the datapath commands and the result strobe
`default_nettype none
module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire spq_pkg::dp_stat_t stat,
  output spq_pkg::ctrl_cmd_t     cmd,
  output logic                   busy,
  output logic                   done
);
  import spq_pkg::*;

  fsm_state_t state, state_next;
  logic       done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    busy       = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        if (start) begin
          cmd.exec = 1'b1;
          if (stat.move) begin
            state_next = FSM_PLACE;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      FSM_PLACE: begin
        busy       = 1'b1;
        cmd.place  = 1'b1;
        done_next  = 1'b1;
        state_next = FSM_IDLE;
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/spq_datapath.sv]
// spq_datapath: sorted shift-register slots with parallel compare
// depends on spq_pkg; commanded by spq_ctrl
`default_nettype none
module spq_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spq_pkg::ctrl_cmd_t cmd,
  input  wire spq_pkg::request_t request,
  output spq_pkg::dp_stat_t      stat,
  output spq_pkg::result_t       result
);
  import spq_pkg::*;

  logic signed [URG_BITS-1:0] urg [CAPACITY];
  logic [TAG_BITS-1:0]        id  [CAPACITY];
  logic signed [URG_BITS-1:0] urg_next [CAPACITY];
  logic [TAG_BITS-1:0]        id_next  [CAPACITY];
  logic signed [URG_BITS-1:0] ins_urg [CAPACITY];
  logic [TAG_BITS-1:0]        ins_id  [CAPACITY];
  logic signed [URG_BITS-1:0] rem_urg [CAPACITY];
  logic [TAG_BITS-1:0]        rem_id  [CAPACITY];
  logic [CNT_BITS-1:0]        count, count_next;
  status_t                    status, status_next;
  logic [ID_BITS-1:0]         removed, removed_next;
  logic signed [URG_BITS-1:0] hold_pri;
  logic [TAG_BITS-1:0]        hold_tag;
  logic signed [URG_BITS-1:0] op_pri;
  logic [TAG_BITS-1:0]        op_tag;
  logic [CAPACITY-1:0]        valid, ge, ge_sh, hit, first, after, rem_mask;
  logic signed [URG_BITS-1:0] found_urg;
  logic                       seen, full, empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      status  <= STAT_OK;
      removed <= '0;
    end else begin
      count   <= count_next;
      status  <= status_next;
      removed <= removed_next;
    end
  end

  always_ff @(posedge clk) begin
    urg <= urg_next;
    id  <= id_next;
    if (cmd.exec) begin
      hold_pri <= request.urgency;
      hold_tag <= request.entry_id[TAG_BITS-1:0];
    end
  end

  // parallel compare across slots
  always_comb begin
    op_pri    = cmd.place ? hold_pri : request.urgency;
    op_tag    = cmd.place ? hold_tag : request.entry_id[TAG_BITS-1:0];
    seen      = 1'b0;
    found_urg = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      valid[k] = (CNT_BITS'(k) < count);
      ge[k]    = valid[k] && (urg[k] <= op_pri);
      hit[k]   = valid[k] && (id[k] == op_tag);
      first[k] = hit[k] && !seen;
      seen     = seen | hit[k];
      after[k] = seen;
      if (first[k]) begin
        found_urg = urg[k];
      end
    end
    ge_sh    = {ge[CAPACITY-2:0], 1'b1};
    rem_mask = (request.req_type == REQ_POP) ? '1 : after;
    full     = (count == CNT_BITS'(CAPACITY));
    empty    = (count == '0);
  end

  // insert and remove slot sources
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ins_urg[k] = urg[k];
      ins_id[k]  = id[k];
      rem_urg[k] = urg[k];
      rem_id[k]  = id[k];
    end
    for (int k = 1; k < CAPACITY; k++) begin
      if (!ge[k] && !ge_sh[k]) begin
        ins_urg[k] = urg[k-1];
        ins_id[k]  = id[k-1];
      end
    end
    for (int k = 0; k < CAPACITY - 1; k++) begin
      if (rem_mask[k]) begin
        rem_urg[k] = urg[k+1];
        rem_id[k]  = id[k+1];
      end
    end
    for (int k = 0; k < CAPACITY; k++) begin
      if (!ge[k] && ge_sh[k]) begin
        ins_urg[k] = op_pri;
        ins_id[k]  = op_tag;
      end
    end
  end

  always_comb begin
    urg_next     = urg;
    id_next      = id;
    count_next   = count;
    status_next  = status;
    removed_next = removed;
    stat         = '0;
    if (cmd.place) begin
      urg_next   = ins_urg;
      id_next    = ins_id;
      count_next = count + 1'b1;
    end else if (cmd.exec) begin
      removed_next = '0;
      status_next  = STAT_OK;
      unique case (request.req_type)
        REQ_INSERT: begin
          if (full) begin
            status_next = STAT_FULL;
          end else begin
            urg_next   = ins_urg;
            id_next    = ins_id;
            count_next = count + 1'b1;
          end
        end
        REQ_POP: begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else begin
            removed_next = ID_BITS'(id[0]);
            urg_next     = rem_urg;
            id_next      = rem_id;
            count_next   = count - 1'b1;
          end
        end
        REQ_UPGRADE: begin
          if (empty) begin
            status_next = STAT_EMPTY;
          end else if (!(|hit)) begin
            status_next = STAT_NOT_FOUND;
          end else if (op_pri >= found_urg) begin
            status_next = STAT_NOT_URGENT;
          end else begin
            urg_next   = rem_urg;
            id_next    = rem_id;
            count_next = count - 1'b1;
            stat.move  = 1'b1;
          end
        end
        default: begin
          status_next = STAT_OK;
        end
      endcase
    end
  end

  always_comb begin
    result.status        = status;
    result.removed_id    = removed;
    result.front_valid   = !empty;
    result.front_id      = empty ? '0 : ID_BITS'(id[0]);
    result.front_urgency = empty ? '0 : urg[0];
    result.occupancy     = 5'(count);
  end

endmodule
`default_nettype wire

[hdl/stable_priority_queue_decrease_key_core.sv]
// stable priority queue with decrease-key: insert, pop and upgrade by tag
// insert and pop: done strobes the cycle after start is taken;
// an upgrade that moves an entry removes it, then re-places it, with busy high during the re-place
// throughput: one request per cycle while busy is low; a moving upgrade takes no new request during its re-place
// reset: synchronous active high, empties the queue; slot contents are left undefined
// depends on spq_pkg, spq_ctrl and spq_datapath
`default_nettype none
module stable_priority_queue_decrease_key_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire spq_pkg::request_t request,
  output logic                   busy,
  output logic                   done,
  output spq_pkg::result_t       result
);
  import spq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  spq_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .result  (result)
  );

endmodule
`default_nettype wire
